// ===== src/cso_pkg.sv =====
// Shared types and constants for the cursor sprite overlay.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package cso_pkg;

  // Fixed field widths
  localparam int unsigned CURSOR_COORD_W = 12;
  localparam int unsigned HOT_X_W        = 4;
  localparam int unsigned HOT_Y_W        = 5;
  localparam int unsigned SPR_WIDTH_W    = 5;
  localparam int unsigned SPR_HEIGHT_W   = 6;
  localparam int unsigned ROW_INDEX_W    = 5;
  localparam int unsigned ROW_BITS_W     = 16;
  localparam int unsigned COLOR_W        = 32;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  // Parameter defaults
  localparam int unsigned MAX_SPRITE_ROWS_DEF = 32;
  localparam int unsigned COORD_BITS_DEF      = 12;

  // Sprite geometry
  localparam int unsigned SPR_MAX_COLS = 16;
  localparam logic [3:0]  TOP_BIT      = 4'd15;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'hFF00_0000;

  // Register reset values
  localparam logic [CURSOR_COORD_W-1:0] POS_X_RST      = 12'd400;
  localparam logic [CURSOR_COORD_W-1:0] POS_Y_RST      = 12'd300;
  localparam logic [HOT_X_W-1:0]        HOT_X_RST      = 4'd0;
  localparam logic [HOT_Y_W-1:0]        HOT_Y_RST      = 5'd0;
  localparam logic [SPR_WIDTH_W-1:0]    SPR_WIDTH_RST  = 5'd12;
  localparam logic [SPR_HEIGHT_W-1:0]   SPR_HEIGHT_RST = 6'd20;
  localparam logic                      ENABLE_RST     = 1'b1;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_LOAD  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_POS_X         = 3'd0,
    CFG_POS_Y         = 3'd1,
    CFG_HOT_X         = 3'd2,
    CFG_HOT_Y         = 3'd3,
    CFG_SPRITE_WIDTH  = 3'd4,
    CFG_SPRITE_HEIGHT = 3'd5,
    CFG_CURSOR_ENABLE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CURSOR_COORD_W-1:0] pos_x;
    logic [CURSOR_COORD_W-1:0] pos_y;
    logic [HOT_X_W-1:0]        hot_x;
    logic [HOT_Y_W-1:0]        hot_y;
    logic [SPR_WIDTH_W-1:0]    sprite_width;
    logic [SPR_HEIGHT_W-1:0]   sprite_height;
    logic                      cursor_enable;
  } cso_cfg_t;

endpackage

`default_nettype wire

// ===== src/cso_if.sv =====
// Handshake channels of the overlay: pixel/load input, result output, config write.
// Depends on cso_pkg.
`default_nettype none

interface cso_in_if
  import cso_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [COORD_BITS-1:0]  pixel_x;
  logic [COORD_BITS-1:0]  pixel_y;
  logic [COLOR_W-1:0]     background;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ROW_BITS_W-1:0]  row_shape;
  logic [ROW_BITS_W-1:0]  row_mask;

  modport source (output valid, opcode, pixel_x, pixel_y, background,
                  row_index, row_shape, row_mask, input ready);
  modport sink   (input valid, opcode, pixel_x, pixel_y, background,
                  row_index, row_shape, row_mask, output ready);
endinterface

interface cso_out_if
  import cso_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               cursor_hit;

  modport source (output valid, pixel_color, cursor_hit, input ready);
  modport sink   (input valid, pixel_color, cursor_hit, output ready);
endinterface

interface cso_cfg_if
  import cso_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/cso_cfg_regs.sv =====
// Configuration register bank of the overlay.
// Depends on cso_pkg and cso_cfg_if.
`default_nettype none

module cso_cfg_regs
  import cso_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cso_cfg_if.sink    cfg_i,
  output cso_cfg_t   cfg_o
);

  cso_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_POS_X:         cfg_d.pos_x         = cfg_i.data[CURSOR_COORD_W-1:0];
        CFG_POS_Y:         cfg_d.pos_y         = cfg_i.data[CURSOR_COORD_W-1:0];
        CFG_HOT_X:         cfg_d.hot_x         = cfg_i.data[HOT_X_W-1:0];
        CFG_HOT_Y:         cfg_d.hot_y         = cfg_i.data[HOT_Y_W-1:0];
        CFG_SPRITE_WIDTH:  cfg_d.sprite_width  = cfg_i.data[SPR_WIDTH_W-1:0];
        CFG_SPRITE_HEIGHT: cfg_d.sprite_height = cfg_i.data[SPR_HEIGHT_W-1:0];
        CFG_CURSOR_ENABLE: cfg_d.cursor_enable = cfg_i.data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x         <= POS_X_RST;
      cfg_q.pos_y         <= POS_Y_RST;
      cfg_q.hot_x         <= HOT_X_RST;
      cfg_q.hot_y         <= HOT_Y_RST;
      cfg_q.sprite_width  <= SPR_WIDTH_RST;
      cfg_q.sprite_height <= SPR_HEIGHT_RST;
      cfg_q.cursor_enable <= ENABLE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/cso_sprite_ram.sv =====
// Sprite row store: one write port, one registered read port.
// Depends on cso_pkg.
`default_nettype none

module cso_sprite_ram
  import cso_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_SPRITE_ROWS_DEF,
  parameter int unsigned AW    = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  wr_en_i,
  input  wire logic [AW-1:0]         wr_addr_i,
  input  wire logic [2*ROW_BITS_W-1:0] wr_data_i,
  input  wire logic                  rd_en_i,
  input  wire logic [AW-1:0]         rd_addr_i,
  output logic      [2*ROW_BITS_W-1:0] rd_data_o
);

  // shape in upper half, mask in lower half
  logic [2*ROW_BITS_W-1:0] mem_q [DEPTH];
  logic [2*ROW_BITS_W-1:0] rd_data_q;

  assign rd_data_o = rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/cursor_sprite_overlay_core.sv =====
// Cursor sprite overlay: composites a 1bpp masked cursor over a pixel stream.
// Throughput: one transaction per cycle, pixel or row load, while the output register
// is free or being drained; set by the four-register pipeline and one sprite row store
// access per cycle. Loads yield no result.
// Reset: rst_ni clears valid bits and loads register defaults; sprite rows stay
// undefined until loaded.
`default_nettype none

module cursor_sprite_overlay_core
  import cso_pkg::*;
#(
  parameter int unsigned MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF,
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cso_in_if.sink    in_i,
  cso_out_if.source out_o,
  cso_cfg_if.sink   cfg_i
);

  // signed window offsets: screen range plus hotspot offset plus sign
  localparam int unsigned CW     = COORD_BITS + 2;
  localparam int unsigned ROW_AW = (MAX_SPRITE_ROWS > 1) ? $clog2(MAX_SPRITE_ROWS) : 1;
  localparam int unsigned IDX_CW = ROW_INDEX_W + 2;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  cso_cfg_t cfg;

  cso_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Static geometry from the registers: window origin and clamped size.
  logic [COORD_BITS-1:0] cx_c, cy_c;
  logic signed [CW-1:0]  org_x, org_y;
  logic signed [CW-1:0]  wid_eff, hgt_eff;

  assign cx_c  = COORD_BITS'(cfg.pos_x);
  assign cy_c  = COORD_BITS'(cfg.pos_y);
  assign org_x = $signed({2'b00, cx_c}) - $signed(CW'(cfg.hot_x));
  assign org_y = $signed({2'b00, cy_c}) - $signed(CW'(cfg.hot_y));

  always_comb begin
    // wide sprite clamps at 16 columns, tall one at the store depth
    if (CW'(cfg.sprite_width) > CW'(SPR_MAX_COLS)) begin
      wid_eff = $signed(CW'(SPR_MAX_COLS));
    end else begin
      wid_eff = $signed(CW'(cfg.sprite_width));
    end
    if (CW'(cfg.sprite_height) > CW'(MAX_SPRITE_ROWS)) begin
      hgt_eff = $signed(CW'(MAX_SPRITE_ROWS));
    end else begin
      hgt_eff = $signed(CW'(cfg.sprite_height));
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages advance together whenever the output
  // register is free or being drained. Bubbles travel as cleared valid bits.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_q, out_valid_d;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: registered input transaction
  logic                   s1_valid_q;
  opcode_e                s1_op_q;
  logic [COORD_BITS-1:0]  s1_px_q, s1_py_q;
  logic [COLOR_W-1:0]     s1_bg_q;
  logic [ROW_INDEX_W-1:0] s1_ridx_q;
  logic [ROW_BITS_W-1:0]  s1_shape_q, s1_mask_q;

  // Stage 2: position relative to sprite corner
  logic                   s2_valid_q;
  opcode_e                s2_op_q;
  logic signed [CW-1:0]   s2_col_q, s2_row_q;
  logic signed [CW-1:0]   s2_col_d, s2_row_d;
  logic [COLOR_W-1:0]     s2_bg_q;
  logic [ROW_INDEX_W-1:0] s2_ridx_q;
  logic [ROW_BITS_W-1:0]  s2_shape_q, s2_mask_q;

  // Stage 3: window decision, sprite row from the store
  logic                   s3_valid_q;
  opcode_e                s3_op_q;
  logic                   s3_in_win_q, s3_in_win_d;
  logic [3:0]             s3_col_q;
  logic [COLOR_W-1:0]     s3_bg_q;

  // Output register
  logic [COLOR_W-1:0]     out_color_q, out_color_d;
  logic                   out_hit_q, out_hit_d;

  assign s2_col_d = $signed({2'b00, s1_px_q}) - org_x;
  assign s2_row_d = $signed({2'b00, s1_py_q}) - org_y;

  assign s3_in_win_d = cfg.cursor_enable
                    && !s2_col_q[CW-1] && (s2_col_q < wid_eff)
                    && !s2_row_q[CW-1] && (s2_row_q < hgt_eff);

  // ---------------------------------------------------------------------------
  // Sprite row store. Loads write and pixels read in stage 2, so program
  // order between loads and pixels is kept by the pipeline itself.
  // ---------------------------------------------------------------------------
  logic                    ram_we, ram_re;
  logic [ROW_AW-1:0]       ram_waddr, ram_raddr;
  logic [2*ROW_BITS_W-1:0] ram_rdata;

  // out-of-range load rows are dropped
  assign ram_we    = adv && s2_valid_q && (s2_op_q == OP_LOAD)
                  && (IDX_CW'(s2_ridx_q) < IDX_CW'(MAX_SPRITE_ROWS));
  assign ram_waddr = ROW_AW'(s2_ridx_q);
  assign ram_re    = adv && s2_valid_q && (s2_op_q == OP_PIXEL) && s3_in_win_d;
  assign ram_raddr = s2_row_q[ROW_AW-1:0];

  cso_sprite_ram #(
    .DEPTH (MAX_SPRITE_ROWS),
    .AW    (ROW_AW)
  ) u_sprite_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i ({s2_shape_q, s2_mask_q}),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Compositing: bit 15 is column 0. Opaque mask bit gives white or black.
  // ---------------------------------------------------------------------------
  logic [3:0]            bit_sel;
  logic [ROW_BITS_W-1:0] rd_shape, rd_mask;
  logic                  mbit, sbit;

  assign rd_shape = ram_rdata[2*ROW_BITS_W-1:ROW_BITS_W];
  assign rd_mask  = ram_rdata[ROW_BITS_W-1:0];
  assign bit_sel  = TOP_BIT - s3_col_q;
  assign mbit     = rd_mask[bit_sel];
  assign sbit     = rd_shape[bit_sel];

  always_comb begin
    out_hit_d   = s3_in_win_q && mbit;
    out_color_d = s3_bg_q;
    if (out_hit_d) begin
      out_color_d = sbit ? COLOR_WHITE : COLOR_BLACK;
    end
    out_valid_d = s3_valid_q && (s3_op_q == OP_PIXEL);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q     <= opcode_e'(in_i.opcode);
      s1_px_q     <= in_i.pixel_x;
      s1_py_q     <= in_i.pixel_y;
      s1_bg_q     <= in_i.background;
      s1_ridx_q   <= in_i.row_index;
      s1_shape_q  <= in_i.row_shape;
      s1_mask_q   <= in_i.row_mask;

      s2_op_q     <= s1_op_q;
      s2_col_q    <= s2_col_d;
      s2_row_q    <= s2_row_d;
      s2_bg_q     <= s1_bg_q;
      s2_ridx_q   <= s1_ridx_q;
      s2_shape_q  <= s1_shape_q;
      s2_mask_q   <= s1_mask_q;

      s3_op_q     <= s2_op_q;
      s3_in_win_q <= s3_in_win_d;
      s3_col_q    <= s2_col_q[3:0];
      s3_bg_q     <= s2_bg_q;

      out_color_q <= out_color_d;
      out_hit_q   <= out_hit_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_color = out_color_q;
  assign out_o.cursor_hit  = out_hit_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hit_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |->
      (out_color_q == COLOR_WHITE) || (out_color_q == COLOR_BLACK))
    else $error("cursor hit with a colour other than white or black");

  a_hit_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_hit_q |-> cfg.cursor_enable)
    else $error("cursor hit while cursor disabled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s3_valid_q && (s3_op_q == OP_LOAD) |=> !out_valid_q)
    else $error("row load produced a result transaction");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for cursor_sprite_overlay_core: directed and random
// pixel and sprite row transactions, each result checked against a local colour predictor.
// Depends on cso_pkg and the cso_in_if, cso_out_if and cso_cfg_if interfaces.
`default_nettype none

module tb;
  import cso_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 7;
  // Settling time past the last result, so that trailing row loads retire too.
  localparam int unsigned PIPE_SETTLE  = 8;
  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned ROWS         = MAX_SPRITE_ROWS_DEF;
  localparam int unsigned CW           = COORD_BITS_DEF;

  typedef struct {
    opcode_e                opcode;
    logic [CW-1:0]          pixel_x;
    logic [CW-1:0]          pixel_y;
    logic [COLOR_W-1:0]     background;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [ROW_BITS_W-1:0]  row_shape;
    logic [ROW_BITS_W-1:0]  row_mask;
  } overlay_item_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               hit;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  cso_in_if #(.COORD_BITS(CW)) in_if ();
  cso_out_if                   out_if ();
  cso_cfg_if                   cfg_if ();

  cursor_sprite_overlay_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the block: register file and sprite row store.
  // Each row word holds shape in the upper half and mask in the lower half.
  cso_cfg_t                 cfg_shadow;
  logic [2*ROW_BITS_W-1:0]  sprite_shadow [ROWS];

  // Expected composited colours, oldest first.
  pixel_result_t colour_q [$];

  int unsigned error_count;
  int unsigned idle_cycles;
  // When set, neither side inserts gaps or stalls: back-to-back transactions.
  bit          steady_flow;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Colour predictor: what the overlay should emit for one pixel under the
  // current shadow registers and rows.
  // ---------------------------------------------------------------------------
  function automatic pixel_result_t composite_pixel(input logic [CW-1:0] px,
                                                    input logic [CW-1:0] py,
                                                    input logic [COLOR_W-1:0] bg);
    pixel_result_t            res;
    int                       wid;
    int                       hgt;
    int                       col;
    int                       row;
    logic [4:0]               bitpos;
    logic [2*ROW_BITS_W-1:0]  word;
    res.color = bg;
    res.hit   = 1'b0;
    // Oversized width/height registers saturate at the sprite's physical size.
    wid = (cfg_shadow.sprite_width > SPR_MAX_COLS) ? SPR_MAX_COLS : cfg_shadow.sprite_width;
    hgt = (cfg_shadow.sprite_height > ROWS) ? ROWS : cfg_shadow.sprite_height;
    // Window origin is hotspot position minus hotspot offset; may go negative.
    col = int'(px) - (int'(cfg_shadow.pos_x) - int'(cfg_shadow.hot_x));
    row = int'(py) - (int'(cfg_shadow.pos_y) - int'(cfg_shadow.hot_y));
    if (cfg_shadow.cursor_enable && col >= 0 && col < wid && row >= 0 && row < hgt) begin
      word   = sprite_shadow[row];
      bitpos = 5'(TOP_BIT - 4'(col));   // bit 15 is column 0
      if (word[bitpos]) begin
        res.color = word[5'(ROW_BITS_W) + bitpos] ? COLOR_WHITE : COLOR_BLACK;
        res.hit   = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic cso_cfg_t make_setting(input int cx, input int cy, input int hx,
                                            input int hy, input int w, input int h,
                                            input int en);
    cso_cfg_t s;
    s.pos_x         = CURSOR_COORD_W'(cx);
    s.pos_y         = CURSOR_COORD_W'(cy);
    s.hot_x         = HOT_X_W'(hx);
    s.hot_y         = HOT_Y_W'(hy);
    s.sprite_width  = SPR_WIDTH_W'(w);
    s.sprite_height = SPR_HEIGHT_W'(h);
    s.cursor_enable = 1'(en);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Fields change at the falling edge; acceptance is sampled at the
  // rising edge. valid is left high after a transaction so that a zero gap
  // gives back-to-back traffic without a low/high pair in one time step.
  // ---------------------------------------------------------------------------
  task automatic send_transaction(input overlay_item_t item);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.opcode     <= item.opcode;
    in_if.pixel_x    <= item.pixel_x;
    in_if.pixel_y    <= item.pixel_y;
    in_if.background <= item.background;
    in_if.row_index  <= item.row_index;
    in_if.row_shape  <= item.row_shape;
    in_if.row_mask   <= item.row_mask;
    do @(posedge clk); while (!in_if.ready);
    // Accepted: row loads update the shadow store, pixels queue a colour.
    if (item.opcode == OP_LOAD) begin
      sprite_shadow[item.row_index] = {item.row_shape, item.row_mask};
    end else begin
      colour_q.push_back(composite_pixel(item.pixel_x, item.pixel_y, item.background));
    end
  endtask

  // Fields that the opcode does not use carry random junk.
  task automatic send_pixel(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic [COLOR_W-1:0] bg);
    overlay_item_t item;
    item.opcode     = OP_PIXEL;
    item.pixel_x    = px;
    item.pixel_y    = py;
    item.background = bg;
    item.row_index  = ROW_INDEX_W'($urandom());
    item.row_shape  = ROW_BITS_W'($urandom());
    item.row_mask   = ROW_BITS_W'($urandom());
    send_transaction(item);
  endtask

  task automatic send_row(input logic [ROW_INDEX_W-1:0] idx,
                          input logic [ROW_BITS_W-1:0] shape,
                          input logic [ROW_BITS_W-1:0] mask);
    overlay_item_t item;
    item.opcode     = OP_LOAD;
    item.pixel_x    = CW'($urandom());
    item.pixel_y    = CW'($urandom());
    item.background = $urandom();
    item.row_index  = idx;
    item.row_shape  = shape;
    item.row_mask   = mask;
    send_transaction(item);
  endtask

  // Hold the sender off until every queued colour has come back.
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
  endtask

  // Drained and past the pipeline depth, so row loads have retired as well.
  task automatic settle_pipeline();
    drain_results();
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register programming: only with the block idle, every register each time.
  // Half the writes carry junk above the register width, which must be dropped.
  // ---------------------------------------------------------------------------
  task automatic apply_setting(input cso_cfg_t setting);
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_DATA_W-1:0] keep;
    int unsigned           width;
    cfg_idx_e              idx;
    settle_pipeline();
    for (int i = 0; i <= int'(CFG_CURSOR_ENABLE); i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_POS_X: begin
          value = CFG_DATA_W'(setting.pos_x);
          width = CURSOR_COORD_W;
        end
        CFG_POS_Y: begin
          value = CFG_DATA_W'(setting.pos_y);
          width = CURSOR_COORD_W;
        end
        CFG_HOT_X: begin
          value = CFG_DATA_W'(setting.hot_x);
          width = HOT_X_W;
        end
        CFG_HOT_Y: begin
          value = CFG_DATA_W'(setting.hot_y);
          width = HOT_Y_W;
        end
        CFG_SPRITE_WIDTH: begin
          value = CFG_DATA_W'(setting.sprite_width);
          width = SPR_WIDTH_W;
        end
        CFG_SPRITE_HEIGHT: begin
          value = CFG_DATA_W'(setting.sprite_height);
          width = SPR_HEIGHT_W;
        end
        CFG_CURSOR_ENABLE: begin
          value = CFG_DATA_W'(setting.cursor_enable);
          width = 1;
        end
        default: begin
          value = '0;
          width = 1;
        end
      endcase
      keep = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
      if ($urandom_range(0, 1) == 1) value = value | ($urandom() & ~keep);
      @(negedge clk);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= value;
      do @(posedge clk); while (!cfg_if.ready);
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_shadow = setting;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each result, none in steady flow.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      repeat (stall) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // Compare each accepted result with the oldest expected colour.
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (colour_q.size() == 0) begin
        $error("unexpected result: pixel_color %h cursor_hit %b",
               out_if.pixel_color, out_if.cursor_hit);
        error_count++;
      end else begin
        want = colour_q.pop_front();
        if (out_if.pixel_color !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, out_if.pixel_color);
          error_count++;
        end
        if (out_if.cursor_hit !== want.hit) begin
          $error("cursor_hit: expected %b, got %b", want.hit, out_if.cursor_hit);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel resets the count.
  always @(posedge clk) begin : hang_watch
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("cursor_sprite_overlay_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every row is loaded first so that no pixel can ever fall on an unloaded row.
  // The marked rows give known hits for the default window (400,300, 12x20).
  task automatic test_reset_defaults();
    for (int r = 0; r < int'(ROWS); r++) begin
      case (r)
        0:       send_row(ROW_INDEX_W'(r), 16'hAAAA, 16'hFFFF);
        1:       send_row(ROW_INDEX_W'(r), 16'hFFFF, 16'h0000);  // fully transparent
        19:      send_row(ROW_INDEX_W'(r), 16'h0000, 16'hFFFF);  // all black
        20:      send_row(ROW_INDEX_W'(r), 16'hFFFF, 16'hFFFF);  // just below default height
        31:      send_row(ROW_INDEX_W'(r), 16'h5555, 16'hFFFF);
        default: send_row(ROW_INDEX_W'(r), ROW_BITS_W'($urandom()), ROW_BITS_W'($urandom()));
      endcase
    end
    send_pixel(CW'(400), CW'(300), 32'h0000_0000);   // top-left corner, white
    send_pixel(CW'(401), CW'(300), 32'hFFFF_FFFF);   // next column, black
    send_pixel(CW'(411), CW'(319), $urandom());      // bottom-right corner
    send_pixel(CW'(412), CW'(300), $urandom());      // one past width
    send_pixel(CW'(405), CW'(320), $urandom());      // one past height
    send_pixel(CW'(399), CW'(299), $urandom());      // above and left
    send_pixel(CW'(400), CW'(301), $urandom());      // transparent row
    send_pixel('0, '0, 32'hFFFF_FFFF);
    send_pixel('1, '1, 32'h0000_0000);
  endtask

  // Window hanging off the top-left and the bottom-right of the screen.
  task automatic test_off_screen_window();
    apply_setting(make_setting(0, 0, 15, 31, 16, 32, 1));
    send_pixel('0, '0, $urandom());                  // last column, last row
    send_pixel(CW'(0), CW'(31), $urandom());
    send_pixel(CW'(15), CW'(0), $urandom());
    send_pixel('1, CW'(0), $urandom());              // far right, no wrap-around hit
    apply_setting(make_setting(4095, 4095, 0, 0, 31, 63, 1));
    send_pixel('1, '1, $urandom());
    send_pixel(CW'(4094), '1, $urandom());
    send_pixel('1, CW'(4094), $urandom());
  endtask

  // Width and height registers above the sprite size saturate.
  task automatic test_size_clamping();
    apply_setting(make_setting(100, 100, 0, 0, 31, 63, 1));
    send_pixel(CW'(115), CW'(131), $urandom());      // last column, last row
    send_pixel(CW'(116), CW'(100), $urandom());      // beyond the 16 columns
    send_pixel(CW'(100), CW'(132), $urandom());      // beyond the 32 rows
    send_pixel(CW'(115), CW'(100), $urandom());
    apply_setting(make_setting(100, 100, 0, 0, 16, 32, 1));
    send_pixel(CW'(115), CW'(131), $urandom());
  endtask

  // Hidden cursor and zero-sized sprites let the background through.
  task automatic test_hidden_cursor();
    apply_setting(make_setting(400, 300, 0, 0, 12, 20, 0));
    send_pixel(CW'(400), CW'(300), $urandom());
    apply_setting(make_setting(400, 300, 0, 0, 0, 20, 1));
    send_pixel(CW'(400), CW'(300), $urandom());
    apply_setting(make_setting(400, 300, 0, 0, 12, 0, 1));
    send_pixel(CW'(400), CW'(300), $urandom());
  endtask

  // Phases of random traffic, each under a fresh register setting. Most pixels
  // are aimed at or just around the window; the rest land anywhere.
  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned phase_len;
    int unsigned pick;
    int          base_x;
    int          base_y;
    cso_cfg_t    s;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        s = make_setting(0, 0, 0, 0, 0, 0, 0);
      end else if (pick == 1) begin
        s = make_setting(4095, 4095, 15, 31, 31, 63, 1);
      end else begin
        s = make_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 15), $urandom_range(0, 31),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(1, 16),
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(1, 32),
                         ($urandom_range(0, 7) != 0));
      end
      apply_setting(s);
      steady_flow = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(30, 70);
      base_x      = int'(cfg_shadow.pos_x) - int'(cfg_shadow.hot_x);
      base_y      = int'(cfg_shadow.pos_y) - int'(cfg_shadow.hot_y);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_row(ROW_INDEX_W'($urandom()), ROW_BITS_W'($urandom()), ROW_BITS_W'($urandom()));
        end else if (pick < 85) begin
          send_pixel(CW'(base_x + int'($urandom_range(0, 17)) - 1),
                     CW'(base_y + int'($urandom_range(0, 33)) - 1), $urandom());
        end else begin
          send_pixel(CW'($urandom()), CW'($urandom()), $urandom());
        end
        // Occasionally let the pipeline run dry before carrying on.
        if ($urandom_range(0, 49) == 0) drain_results();
        sent++;
      end
      steady_flow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst_n            = 1'b0;
    error_count      = 0;
    idle_cycles      = 0;
    steady_flow      = 1'b0;
    in_if.valid      = 1'b0;
    in_if.opcode     = OP_PIXEL;
    in_if.pixel_x    = '0;
    in_if.pixel_y    = '0;
    in_if.background = '0;
    in_if.row_index  = '0;
    in_if.row_shape  = '0;
    in_if.row_mask   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_POS_X;
    cfg_if.data      = '0;
    cfg_shadow = make_setting(POS_X_RST, POS_Y_RST, HOT_X_RST, HOT_Y_RST,
                              SPR_WIDTH_RST, SPR_HEIGHT_RST, ENABLE_RST);
    foreach (sprite_shadow[r]) sprite_shadow[r] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_off_screen_window();
    test_size_clamping();
    test_hidden_cursor();
    test_random_traffic();

    // Wait for the tail, then a few more cycles to catch stray results.
    drain_results();
    repeat (PIPE_SETTLE) @(posedge clk);
    if (error_count == 0 && colour_q.size() == 0) begin
      $display("cursor_sprite_overlay_core: match");
    end else begin
      $display("cursor_sprite_overlay_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
